FILE: rtl/csm_pkg.sv
`timescale 1ns / 1ps
package csm_pkg;
	localparam int CSM_NUM_RESOURCES = 4;
	localparam int CSM_NUM_PROCESSES = 16;
	localparam int CSM_MAX_WAKES = 15;
	localparam int CSM_HELD_DEPTH = CSM_NUM_PROCESSES * CSM_NUM_RESOURCES;
	localparam int CSM_QUEUE_DEPTH = CSM_NUM_RESOURCES * CSM_NUM_PROCESSES;

	localparam logic [1:0] KIND_WAIT = 2'd0;
	localparam logic [1:0] KIND_SIGNAL = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [2:0] ST_GRANTED = 3'd0;
	localparam logic [2:0] ST_BLOCKED = 3'd1;
	localparam logic [2:0] ST_EXIT = 3'd2;
	localparam logic [2:0] ST_POOL = 3'd3;
	localparam logic [2:0] ST_HANDOFF = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [2:0] REG_DEFINED = 3'd0;
	localparam logic [2:0] REG_COUNT_A = 3'd1;
	localparam logic [2:0] REG_COUNT_B = 3'd2;
	localparam logic [2:0] REG_COUNT_C = 3'd3;
	localparam logic [2:0] REG_COUNT_D = 3'd4;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] process_id;
		logic [1:0] resource;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] woken_process;
		logic       last;
	} rsp_t;

	// Classified command passed from the front end to the executor.
	typedef enum logic [1:0] {
		CMD_EXIT,
		CMD_WAIT,
		CMD_SIGNAL,
		CMD_RELEASE
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t     cmd;
		logic [3:0] process_id;
		logic [1:0] resource;
	} cmd_t;

	typedef enum logic [3:0] {
		EX_CLEAR,
		EX_IDLE,
		EX_EXEC,
		EX_WAKE_RD,
		EX_WAKE_WR,
		EX_REL_READ,
		EX_REL_CLEAR,
		EX_REL_STEP,
		EX_DONE
	} ex_state_t;
endpackage

FILE: rtl/csm_front.sv
`timescale 1ns / 1ps
module csm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  csm_pkg::req_t       in_data,
	input  logic [2:0]          resources_defined,
	output logic                q_valid,
	input  logic                q_ready,
	output csm_pkg::cmd_t       q_data
);
	import csm_pkg::*;

	cmd_t cmd;
	logic keep;
	logic push;
	logic pop;
	cmd_t fifo_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	// Classify the request; a wait or signal on an undefined resource turns into an exit, and a none request is dropped.
	always_comb begin
		cmd.process_id = in_data.process_id;
		cmd.resource = in_data.resource;
		keep = 1'b1;
		case (in_data.kind)
			KIND_WAIT, KIND_SIGNAL: begin
				if ({1'b0, in_data.resource} < resources_defined) begin
					cmd.cmd = (in_data.kind == KIND_WAIT) ? CMD_WAIT : CMD_SIGNAL;
				end else begin
					cmd.cmd = CMD_EXIT;
				end
			end
			KIND_RELEASE: cmd.cmd = CMD_RELEASE;
			default: begin
				cmd.cmd = CMD_EXIT;
				keep = 1'b0;
			end
		endcase
	end

	// Two-entry queue between classification and execution.
	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_data = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cmd;
	end
endmodule

FILE: rtl/csm_ram.sv
`timescale 1ns / 1ps
module csm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/csm_exec.sv
`timescale 1ns / 1ps
module csm_exec (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  csm_pkg::cmd_t q_data,
	input  logic [31:0]   caps,
	output logic          out_valid,
	input  logic          out_stall,
	output csm_pkg::rsp_t out_data
);
	import csm_pkg::*;

	localparam int QW = $clog2(CSM_NUM_PROCESSES);
	localparam int FW = $clog2(CSM_NUM_PROCESSES + 1);
	localparam int AW = $clog2(CSM_HELD_DEPTH);
	localparam int WAW = $clog2(CSM_QUEUE_DEPTH);

	ex_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [1:0] res_q;
	logic [7:0] cnt_q;
	logic [3:0] wakes_q;
	logic [3:0] wake_pid_q;
	logic [AW-1:0] clr_q;

	logic [7:0] granted_q [CSM_NUM_RESOURCES];
	logic [QW-1:0] head_q [CSM_NUM_RESOURCES];
	logic [FW-1:0] fill_q [CSM_NUM_RESOURCES];

	// Held table, addressed by process and resource.
	logic h_we;
	logic [AW-1:0] h_waddr, h_raddr;
	logic [7:0] h_wdata, h_rdata;
	// Waiter FIFO storage, one circular region per resource.
	logic w_we;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [3:0] w_wdata, w_rdata;

	csm_ram #(.WIDTH(8), .DEPTH(CSM_HELD_DEPTH)) u_held (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);
	csm_ram #(.WIDTH(4), .DEPTH(CSM_QUEUE_DEPTH)) u_waiters (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	logic out_valid_q;
	rsp_t out_q;
	logic emit;
	rsp_t emit_rsp;
	logic [1:0] r;
	logic [7:0] cap;
	logic [QW:0] tail_sum;
	logic [QW-1:0] tail;
	logic [QW-1:0] head_nx;
	logic [7:0] held_inc;
	logic slot_free;
	logic grant_ok;
	logic queue_free;
	logic has_waiter;
	logic wake_ok;

	assign r = (state_q == EX_IDLE) ? q_data.resource : res_q;
	assign cap = caps[{r, 3'd0} +: 8];
	assign tail_sum = {1'b0, head_q[r]} + fill_q[r];
	assign tail = (tail_sum >= (QW+1)'(CSM_NUM_PROCESSES)) ?
		QW'(tail_sum - (QW+1)'(CSM_NUM_PROCESSES)) : tail_sum[QW-1:0];
	assign head_nx = (head_q[r] == QW'(CSM_NUM_PROCESSES - 1)) ? '0 : head_q[r] + 1'b1;
	assign held_inc = (h_rdata == 8'hFF) ? h_rdata : h_rdata + 8'd1;
	assign slot_free = !out_valid_q || !out_stall;
	assign grant_ok = granted_q[r] < cap;
	assign queue_free = fill_q[r] < FW'(CSM_NUM_PROCESSES);
	assign has_waiter = fill_q[r] != '0;
	assign wake_ok = wakes_q != 4'(CSM_MAX_WAKES);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign w_raddr = {r, head_q[r]};
	assign w_waddr = {res_q, tail};
	assign w_wdata = cmd_q.process_id;

	// Sequencer: next state, RAM control and the result to emit.
	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		h_we = 1'b0;
		h_waddr = {cmd_q.process_id, res_q};
		h_wdata = 8'd0;
		h_raddr = {cmd_q.process_id, res_q};
		w_we = 1'b0;
		emit = 1'b0;
		emit_rsp = '{status: ST_EXIT, woken_process: 4'd0, last: 1'b1};
		case (state_q)
			EX_CLEAR: begin
				// Zero the held table once after reset.
				h_we = 1'b1;
				h_waddr = clr_q;
				if (clr_q == AW'(CSM_HELD_DEPTH - 1)) state_d = EX_IDLE;
			end
			EX_IDLE: begin
				q_ready = slot_free;
				h_raddr = {q_data.process_id, q_data.resource};
				if (q_valid && slot_free) begin
					case (q_data.cmd)
						CMD_EXIT: emit = 1'b1;
						CMD_RELEASE: state_d = EX_REL_READ;
						default: state_d = EX_EXEC;
					endcase
				end
			end
			EX_EXEC: begin
				if (slot_free) begin
					state_d = EX_IDLE;
					emit = 1'b1;
					if (cmd_q.cmd == CMD_WAIT) begin
						if (grant_ok) begin
							h_we = 1'b1;
							h_wdata = held_inc;
							emit_rsp.status = ST_GRANTED;
						end else if (queue_free) begin
							w_we = 1'b1;
							emit_rsp.status = ST_BLOCKED;
						end
					end else if (h_rdata != 8'd0) begin
						h_we = 1'b1;
						h_wdata = h_rdata - 8'd1;
						if (has_waiter) begin
							emit = 1'b0;
							state_d = EX_WAKE_RD;
						end else begin
							emit_rsp.status = ST_POOL;
						end
					end
				end
			end
			EX_WAKE_RD: begin
				// Read the woken process's held count after any earlier write.
				h_raddr = {wake_pid_q, res_q};
				state_d = EX_WAKE_WR;
			end
			EX_WAKE_WR: begin
				h_raddr = {wake_pid_q, res_q};
				h_waddr = {wake_pid_q, res_q};
				if (slot_free) begin
					h_we = 1'b1;
					h_wdata = held_inc;
					emit = 1'b1;
					emit_rsp = '{status: ST_HANDOFF, woken_process: wake_pid_q,
						last: (cmd_q.cmd != CMD_RELEASE)};
					state_d = (cmd_q.cmd == CMD_RELEASE) ? EX_REL_STEP : EX_IDLE;
				end
			end
			EX_REL_READ: state_d = EX_REL_CLEAR;
			EX_REL_CLEAR: begin
				// Clear the held entry; its old count drives the walk.
				h_we = 1'b1;
				state_d = EX_REL_STEP;
			end
			EX_REL_STEP: begin
				if (cnt_q == 8'd0) begin
					state_d = (res_q == 2'd3) ? EX_DONE : EX_REL_READ;
				end else if (has_waiter && wake_ok) begin
					state_d = EX_WAKE_RD;
				end
			end
			EX_DONE: begin
				if (slot_free) begin
					emit = 1'b1;
					emit_rsp.status = ST_DONE;
					state_d = EX_IDLE;
				end
			end
			default: state_d = EX_IDLE;
		endcase
	end

	// State register, counters and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_CLEAR;
			clr_q <= '0;
			cmd_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			wakes_q <= '0;
			wake_pid_q <= '0;
			cnt_q <= '0;
			res_q <= '0;
			for (int i = 0; i < CSM_NUM_RESOURCES; i++) begin
				granted_q[i] <= '0;
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q <= emit_rsp;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				EX_CLEAR: clr_q <= clr_q + 1'b1;
				EX_IDLE: begin
					if (q_valid && slot_free) begin
						cmd_q <= q_data;
						res_q <= (q_data.cmd == CMD_RELEASE) ? 2'd0 : q_data.resource;
						wakes_q <= '0;
					end
				end
				EX_EXEC: begin
					if (slot_free) begin
						if (cmd_q.cmd == CMD_WAIT) begin
							if (grant_ok)
								granted_q[res_q] <= granted_q[res_q] + 8'd1;
							else if (queue_free)
								fill_q[res_q] <= fill_q[res_q] + 1'b1;
						end else if (h_rdata != 8'd0) begin
							if (has_waiter) begin
								wake_pid_q <= w_rdata;
								head_q[res_q] <= head_nx;
								fill_q[res_q] <= fill_q[res_q] - 1'b1;
							end else if (granted_q[res_q] != 8'd0) begin
								granted_q[res_q] <= granted_q[res_q] - 8'd1;
							end
						end
					end
				end
				EX_REL_CLEAR: cnt_q <= h_rdata;
				EX_REL_STEP: begin
					if (cnt_q == 8'd0) begin
						res_q <= res_q + 2'd1;
					end else begin
						cnt_q <= cnt_q - 8'd1;
						if (has_waiter && wake_ok) begin
							wake_pid_q <= w_rdata;
							head_q[res_q] <= head_nx;
							fill_q[res_q] <= fill_q[res_q] - 1'b1;
							wakes_q <= wakes_q + 4'd1;
						end else if (granted_q[res_q] != 8'd0) begin
							granted_q[res_q] <= granted_q[res_q] - 8'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/csm_regs.sv
`timescale 1ns / 1ps
module csm_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [2:0]  resources_defined,
	output logic [31:0] caps
);
	import csm_pkg::*;

	logic [2:0] def_q;
	logic [7:0] cap_q [4];
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign resources_defined = def_q;
	assign caps = {cap_q[3], cap_q[2], cap_q[1], cap_q[0]};

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_q <= 3'd4;
			for (int i = 0; i < 4; i++) cap_q[i] <= 8'd1;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_DEFINED: def_q <= pwdata[2:0];
				REG_COUNT_A: cap_q[0] <= pwdata[7:0];
				REG_COUNT_B: cap_q[1] <= pwdata[7:0];
				REG_COUNT_C: cap_q[2] <= pwdata[7:0];
				REG_COUNT_D: cap_q[3] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (idx)
			REG_DEFINED: prdata = {29'd0, def_q};
			REG_COUNT_A: prdata = {24'd0, cap_q[0]};
			REG_COUNT_B: prdata = {24'd0, cap_q[1]};
			REG_COUNT_C: prdata = {24'd0, cap_q[2]};
			REG_COUNT_D: prdata = {24'd0, cap_q[3]};
			default: prdata = 32'd0;
		endcase
	end
endmodule

FILE: rtl/counting_semaphore_manager.sv
`timescale 1ns / 1ps
// With the executor idle, exit is valid in the cycle after the request is taken; wait
// and signal pass through EX_EXEC first, and a hand-off also through EX_WAKE_RD and
// EX_WAKE_WR. The executor takes one request per pass; a release reads, clears and steps
// each resource, one step per held instance, waking up to 15 waiters in all.
// Result stalls hold the executor; a two-entry queue buffers requests in between.
// Reset (arst_n low) clears counts and queue pointers; the held table is then zeroed
// entry by entry in EX_CLEAR while the input stalls once the queue is full.
module counting_semaphore_manager (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  csm_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output csm_pkg::rsp_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import csm_pkg::*;

	logic [2:0] defined;
	logic [31:0] caps;
	logic q_valid, q_ready;
	cmd_t q_data;

	csm_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.resources_defined(defined), .caps(caps)
	);

	csm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .resources_defined(defined),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	csm_exec u_exec (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_data(q_data), .caps(caps), .out_valid(out_valid),
		.out_stall(out_stall), .out_data(out_data)
	);
endmodule

FILE: tb/tb_counting_semaphore_manager.sv
`timescale 1ns / 1ps
module tb_counting_semaphore_manager;
	import csm_pkg::*;

	localparam int NRES = CSM_NUM_RESOURCES;
	localparam int NPROC = CSM_NUM_PROCESSES;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	counting_semaphore_manager dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the semaphore tables and registers.
	logic [2:0] defined_cnt;
	logic [7:0] capacity [NRES];
	logic [7:0] granted [NRES];
	logic [7:0] held [NPROC][NRES];
	logic [3:0] waiters [NRES][NPROC];
	logic [3:0] head [NRES];
	logic [4:0] fill [NRES];

	rsp_t expected_rsp [$];
	int errors;
	int idle_cycles;
	bit done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic model_reset();
		defined_cnt = 3'd4;
		for (int r = 0; r < NRES; r++) begin
			capacity[r] = 8'd1;
			granted[r] = '0;
			head[r] = '0;
			fill[r] = '0;
			for (int p = 0; p < NPROC; p++) begin
				held[p][r] = '0;
				waiters[r][p] = '0;
			end
		end
	endtask

	function automatic rsp_t mk(logic [2:0] st, logic [3:0] w, logic l);
		rsp_t x;
		x.status = st;
		x.woken_process = w;
		x.last = l;
		return x;
	endfunction

	task automatic bump_held(int p, int r);
		if (held[p][r] != 8'd255)
			held[p][r]++;
	endtask

	function automatic int pop_waiter(int r);
		int w;
		w = int'(waiters[r][head[r]]);
		head[r] = (head[r] == NPROC - 1) ? 4'd0 : head[r] + 4'd1;
		fill[r]--;
		return w;
	endfunction

	// Compute the result transactions of one request and update the shadow state.
	task automatic predict_request(req_t q);
		int p;
		int r;
		int n;
		int h;
		int w;
		p = int'(q.process_id);
		r = int'(q.resource);
		if (q.kind == KIND_RELEASE) begin
			n = 0;
			for (int res = 0; res < NRES; res++) begin
				h = int'(held[p][res]);
				held[p][res] = '0;
				for (int i = 0; i < h; i++) begin
					if (fill[res] > 0 && n < CSM_MAX_WAKES) begin
						w = pop_waiter(res);
						bump_held(w, res);
						expected_rsp.push_back(mk(ST_HANDOFF, 4'(w), 1'b0));
						n++;
					end else if (granted[res] > 0) begin
						granted[res]--;
					end
				end
			end
			expected_rsp.push_back(mk(ST_DONE, 4'd0, 1'b1));
		end else if (q.kind == KIND_WAIT || q.kind == KIND_SIGNAL) begin
			if (r >= defined_cnt) begin
				expected_rsp.push_back(mk(ST_EXIT, 4'd0, 1'b1));
			end else if (q.kind == KIND_WAIT) begin
				if (granted[r] < capacity[r]) begin
					granted[r]++;
					bump_held(p, r);
					expected_rsp.push_back(mk(ST_GRANTED, 4'd0, 1'b1));
				end else if (fill[r] < NPROC) begin
					waiters[r][(head[r] + fill[r]) % NPROC] = 4'(p);
					fill[r]++;
					expected_rsp.push_back(mk(ST_BLOCKED, 4'd0, 1'b1));
				end else begin
					expected_rsp.push_back(mk(ST_EXIT, 4'd0, 1'b1));
				end
			end else if (held[p][r] == 0) begin
				expected_rsp.push_back(mk(ST_EXIT, 4'd0, 1'b1));
			end else begin
				held[p][r]--;
				if (fill[r] > 0) begin
					w = pop_waiter(r);
					bump_held(w, r);
					expected_rsp.push_back(mk(ST_HANDOFF, 4'(w), 1'b1));
				end else begin
					if (granted[r] > 0)
						granted[r]--;
					expected_rsp.push_back(mk(ST_POOL, 4'd0, 1'b1));
				end
			end
		end
	endtask

	// Send one request transaction after a random gap; valid stays up back to back.
	task automatic send_request(logic [1:0] kind, logic [3:0] pid, logic [1:0] res);
		req_t q;
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		q.kind = kind;
		q.process_id = pid;
		q.resource = res;
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_request(q);
	endtask

	task automatic send_random(int wait_weight);
		int k;
		k = $urandom_range(0, 99);
		if (k < wait_weight)
			send_request(KIND_WAIT, 4'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
		else if (k < 90)
			send_request(KIND_SIGNAL, 4'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
		else if (k < 98)
			send_request(KIND_RELEASE, 4'($urandom_range(0, 15)),
				2'($urandom_range(0, 3)));
		else
			send_request(KIND_NONE, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Register write: setup phase, then access phase, then idle.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == REG_DEFINED)
			defined_cnt = val[2:0];
		else
			capacity[idx - 1] = val[7:0];
	endtask

	task automatic test_directed();
		send_request(KIND_WAIT, 4'd0, 2'd0);
		send_request(KIND_WAIT, 4'd15, 2'd0);
		send_request(KIND_WAIT, 4'd3, 2'd0);
		send_request(KIND_SIGNAL, 4'd0, 2'd0);
		send_request(KIND_SIGNAL, 4'd9, 2'd3);
		send_request(KIND_WAIT, 4'd5, 2'd3);
		send_request(KIND_NONE, 4'd5, 2'd3);
		send_request(KIND_RELEASE, 4'd15, 2'd2);
		send_request(KIND_RELEASE, 4'd5, 2'd0);
		send_request(KIND_SIGNAL, 4'd3, 2'd0);
		drain();
		write_reg(REG_DEFINED, 32'd2);
		send_request(KIND_WAIT, 4'd1, 2'd2);
		send_request(KIND_SIGNAL, 4'd1, 2'd3);
		send_request(KIND_WAIT, 4'd1, 2'd1);
		drain();
		write_reg(REG_DEFINED, 32'd0);
		send_request(KIND_WAIT, 4'd2, 2'd0);
		drain();
	endtask

	// Fill a queue to its limit, overflow it, then wake many in one release.
	task automatic test_queue_full();
		write_reg(REG_DEFINED, 32'd4);
		write_reg(REG_COUNT_B, 32'd0);
		write_reg(REG_COUNT_A, 32'd255);
		for (int i = 0; i < 17; i++)
			send_request(KIND_WAIT, 4'd0, 2'd0);
		for (int i = 0; i < 17; i++)
			send_request(KIND_WAIT, i[3:0], 2'd1);
		drain();
		write_reg(REG_COUNT_A, {24'd0, granted[0]});
		for (int i = 0; i < 17; i++)
			send_request(KIND_WAIT, i[3:0], 2'd0);
		drain();
		send_request(KIND_RELEASE, 4'd0, 2'd0);
		send_request(KIND_RELEASE, 4'd1, 2'd0);
		drain();
	endtask

	task automatic test_random(int items, int wait_weight);
		for (int i = 0; i < items; i++)
			send_random(wait_weight);
		drain();
	endtask

	// Result side: random stall, check each transaction.
	initial begin
		rsp_t exp_rsp;
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (expected_rsp.size() == 0) begin
				$display("%0t: result expected none actual %p", $time, out_data);
				errors++;
			end else begin
				exp_rsp = expected_rsp.pop_front();
				if (out_data.status !== exp_rsp.status)
					$display("%0t: status expected %0d actual %0d", $time,
						exp_rsp.status, out_data.status);
				if (out_data.woken_process !== exp_rsp.woken_process)
					$display("%0t: woken_process expected %0d actual %0d", $time,
						exp_rsp.woken_process, out_data.woken_process);
				if (out_data.last !== exp_rsp.last)
					$display("%0t: last expected %0d actual %0d", $time,
						exp_rsp.last, out_data.last);
				if (out_data !== exp_rsp)
					errors++;
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT && !done) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		errors = 0;
		idle_cycles = 0;
		done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_queue_full();
		write_reg(REG_COUNT_A, 32'd2);
		write_reg(REG_COUNT_B, 32'd1);
		write_reg(REG_COUNT_C, 32'd3);
		write_reg(REG_COUNT_D, 32'd0);
		test_random(180, 55);
		write_reg(REG_DEFINED, 32'd3);
		write_reg(REG_COUNT_D, 32'd255);
		write_reg(REG_COUNT_C, 32'd0);
		test_random(130, 45);
		write_reg(REG_DEFINED, 32'd7);
		write_reg(REG_COUNT_A, 32'd1);
		write_reg(REG_COUNT_C, 32'd1);
		test_random(130, 60);
		done = 1'b1;
		if (errors == 0 && expected_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

FILE: files.f
rtl/csm_pkg.sv
rtl/csm_front.sv
rtl/csm_ram.sv
rtl/csm_exec.sv
rtl/csm_regs.sv
rtl/counting_semaphore_manager.sv
tb/tb_counting_semaphore_manager.sv
